// ----- rtl/ffmu_pkg.sv -----
// ----------------------------------------------------------------------------
// ffmu_pkg: shared types, constants and fixed-point helpers
// Holds the grid geometry, action and register codes, the stencil layout and
// the saturating Q-format arithmetic of the flow field update.
// ----------------------------------------------------------------------------
package ffmu_pkg;

  localparam int GRID_SIZE = 256;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int COORD_W   = $clog2(GRID_SIZE + 2);
  localparam int ENTRY_W   = 192;
  localparam int WIN_N     = 13;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] CFG_ALPHA = 3'd0;
  localparam logic [2:0] CFG_TEMP  = 3'd1;
  localparam logic [2:0] CFG_PHI1  = 3'd2;
  localparam logic [2:0] CFG_PHI2  = 3'd3;
  localparam logic [2:0] CFG_GAMMA = 3'd4;

  // Stencil slots: centre, its four neighbors, then the outer ring.
  localparam logic [3:0] WIN_C  = 4'd0;
  localparam logic [3:0] WIN_N1 = 4'd1;
  localparam logic [3:0] WIN_S1 = 4'd2;
  localparam logic [3:0] WIN_E1 = 4'd3;
  localparam logic [3:0] WIN_W1 = 4'd4;
  localparam logic [3:0] WIN_NN = 4'd5;
  localparam logic [3:0] WIN_SS = 4'd6;
  localparam logic [3:0] WIN_EE = 4'd7;
  localparam logic [3:0] WIN_WW = 4'd8;
  localparam logic [3:0] WIN_NE = 4'd9;
  localparam logic [3:0] WIN_NW = 4'd10;
  localparam logic [3:0] WIN_SE = 4'd11;
  localparam logic [3:0] WIN_SW = 4'd12;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_FETCH = 9'b000000100,
    ST_RES   = 9'b000001000,
    ST_GRAD  = 9'b000010000,
    ST_FIN   = 9'b000100000,
    ST_DIFF  = 9'b001000000,
    ST_DEC   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } win_off_t;

  localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
  localparam logic signed [31:0] QMAX   = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN   = 32'sh80000000;

  function automatic logic signed [31:0] qsat33(input logic signed [32:0] s);
    if (s[32] != s[31]) begin
      return s[32] ? QMIN : QMAX;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return qsat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return qsat33({a[31], a} - {b[31], b});
  endfunction

  function automatic logic signed [31:0] qabs(input logic signed [31:0] a);
    if (a == QMIN) begin
      return QMAX;
    end
    return a[31] ? -a : a;
  endfunction

  // Full product, floor shift, saturate.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b);
    s = p >>> FRAC_BITS;
    if (s > QMAX64) begin
      return QMAX;
    end
    if (s < QMIN64) begin
      return QMIN;
    end
    return s[31:0];
  endfunction

  function automatic win_off_t win_off(input logic [3:0] idx);
    win_off_t o;
    o = '{dr: 3'sd0, dc: 3'sd0};
    unique case (idx)
      WIN_N1:  o = '{dr: -3'sd1, dc:  3'sd0};
      WIN_S1:  o = '{dr:  3'sd1, dc:  3'sd0};
      WIN_E1:  o = '{dr:  3'sd0, dc:  3'sd1};
      WIN_W1:  o = '{dr:  3'sd0, dc: -3'sd1};
      WIN_NN:  o = '{dr: -3'sd2, dc:  3'sd0};
      WIN_SS:  o = '{dr:  3'sd2, dc:  3'sd0};
      WIN_EE:  o = '{dr:  3'sd0, dc:  3'sd2};
      WIN_WW:  o = '{dr:  3'sd0, dc: -3'sd2};
      WIN_NE:  o = '{dr: -3'sd1, dc:  3'sd1};
      WIN_NW:  o = '{dr: -3'sd1, dc: -3'sd1};
      WIN_SE:  o = '{dr:  3'sd1, dc:  3'sd1};
      WIN_SW:  o = '{dr:  3'sd1, dc: -3'sd1};
      default: o = '{dr:  3'sd0, dc:  3'sd0};
    endcase
    return o;
  endfunction

  // Neighbor slot of a centre or first-ring slot.
  function automatic logic [3:0] nbr(input logic [3:0] site, input logic [1:0] dir);
    logic [3:0] r;
    r = WIN_C;
    unique case (site)
      WIN_C: begin
        unique case (dir)
          DIR_UP:    r = WIN_N1;
          DIR_DOWN:  r = WIN_S1;
          DIR_RIGHT: r = WIN_E1;
          default:   r = WIN_W1;
        endcase
      end
      WIN_N1: begin
        unique case (dir)
          DIR_UP:    r = WIN_NN;
          DIR_DOWN:  r = WIN_C;
          DIR_RIGHT: r = WIN_NE;
          default:   r = WIN_NW;
        endcase
      end
      WIN_S1: begin
        unique case (dir)
          DIR_UP:    r = WIN_C;
          DIR_DOWN:  r = WIN_SS;
          DIR_RIGHT: r = WIN_SE;
          default:   r = WIN_SW;
        endcase
      end
      WIN_E1: begin
        unique case (dir)
          DIR_UP:    r = WIN_NE;
          DIR_DOWN:  r = WIN_SE;
          DIR_RIGHT: r = WIN_EE;
          default:   r = WIN_C;
        endcase
      end
      WIN_W1: begin
        unique case (dir)
          DIR_UP:    r = WIN_NW;
          DIR_DOWN:  r = WIN_SW;
          DIR_RIGHT: r = WIN_C;
          default:   r = WIN_WW;
        endcase
      end
      default: r = WIN_C;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ffmu_ram.sv -----
// ----------------------------------------------------------------------------
// ffmu_ram: generic single-port RAM
// One access per cycle, write or read, with a registered read port.
// ----------------------------------------------------------------------------
module ffmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/flow_field_metropolis_update_top.sv -----
// ----------------------------------------------------------------------------
// flow_field_metropolis_update_top: Metropolis update of a flow field
// Grid store, stencil fetch, sequenced energy datapath and result register.
// ----------------------------------------------------------------------------
// All per-site state (mean density, density change, flow, prior flow) lives in
// one RAM entry of 192 bits per site, so a load writes one entry and a read
// fetches one. A request is taken only in idle; its result goes to an output
// register, so the next request is taken while that result waits. Load and
// unused actions go straight to the output state, a read or an edge step through
// a read state first. A step at an interior site fetches the 13-site stencil
// (one RAM read per cycle), runs one energy evaluation before and one after the
// change on one shared 32x32 multiplier and one saturating adder, forms the
// energy difference and decision, and then hands off the result. An accepted
// step writes the centre entry back in the decision cycle. There is no reset
// pass: an entry never loaded reads as whatever the RAM holds.
// Input tdata fields: row, col, rho_mean, rho_diff, u_prior, v_prior, u_step,
// v_step, accept_threshold; tuser carries the action. Output tdata fields:
// accepted, u_value, v_value, energy_change, accept_total.
// ----------------------------------------------------------------------------
module flow_field_metropolis_update_top
  import ffmu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row[7:0] col[15:8] rho_mean[47:16] rho_diff[79:48] u_prior[111:80]
  // v_prior[143:112] u_step[175:144] v_step[207:176] accept_threshold[238:208]
  input  logic [239:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted[0] u_value[32:1] v_value[64:33] energy_change[96:65]
  // accept_total[128:97]
  output logic [135:0] m_axis_tdata
);

  // request fields
  logic [7:0]         in_row, in_col;
  logic signed [31:0] in_rho_mean, in_rho_diff, in_u_prior, in_v_prior;
  logic signed [31:0] in_u_step, in_v_step;
  logic [30:0]        in_thr;
  logic               in_acc;
  logic               on_grid, interior;

  assign in_row      = s_axis_tdata[7:0];
  assign in_col      = s_axis_tdata[15:8];
  assign in_rho_mean = s_axis_tdata[47:16];
  assign in_rho_diff = s_axis_tdata[79:48];
  assign in_u_prior  = s_axis_tdata[111:80];
  assign in_v_prior  = s_axis_tdata[143:112];
  assign in_u_step   = s_axis_tdata[175:144];
  assign in_v_step   = s_axis_tdata[207:176];
  assign in_thr      = s_axis_tdata[238:208];

  assign on_grid  = (int'(in_row) < GRID_SIZE) && (int'(in_col) < GRID_SIZE);
  assign interior = (in_row >= 8'd2) && (in_col >= 8'd2) &&
                    (int'(in_row) + 3 <= GRID_SIZE) && (int'(in_col) + 3 <= GRID_SIZE);

  // configuration registers
  logic signed [31:0] alpha_q, temp_q, phi1_q, phi2_q, gamma_q;

  // control
  state_e      state_q, state_d;
  logic [3:0]  k_q;
  logic [2:0]  j_q;
  logic        pass_q;
  logic [31:0] cnt_q;
  logic        out_valid_q;
  logic [135:0] out_data_q;

  // request context
  logic [7:0]         row_q, col_q;
  logic signed [31:0] inc_u_q, inc_v_q;
  logic [30:0]        thr_q;

  // stencil window and datapath registers
  logic signed [31:0] win_m_q [WIN_N];
  logic signed [31:0] win_d_q [WIN_N];
  logic signed [31:0] win_u_q [WIN_N];
  logic signed [31:0] win_v_q [WIN_N];
  logic signed [31:0] cpx_q, cpy_q, ucen_q, vcen_q;
  logic signed [31:0] d_q, p_q, m_q, acc_q, jd_q, jr_q, before_q;

  // pending result
  logic               res_acc_q;
  logic signed [31:0] res_u_q, res_v_q, res_chg_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- memory
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic [3:0]         fetch_idx;
  win_off_t           off;
  logic [COORD_W-1:0] base_r, base_c, site_r, site_c;
  logic               accept_w;

  // Fetch the stencil in slot order; the centre slot serves decision writes.
  assign fetch_idx = (state_q == ST_FETCH && k_q < 4'(WIN_N)) ? k_q : WIN_C;
  assign off       = win_off(fetch_idx);
  assign base_r    = (state_q == ST_IDLE) ? COORD_W'(in_row) : COORD_W'(row_q);
  assign base_c    = (state_q == ST_IDLE) ? COORD_W'(in_col) : COORD_W'(col_q);
  assign site_r    = base_r + COORD_W'(off.dr);
  assign site_c    = base_c + COORD_W'(off.dc);
  assign mem_addr  = ADDR_W'(ADDR_W'(site_r) * ADDR_W'(GRID_SIZE) + ADDR_W'(site_c));

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {cpy_q, cpx_q, vcen_q, ucen_q, win_d_q[WIN_C], win_m_q[WIN_C]};
    if (state_q == ST_IDLE) begin
      mem_we    = in_acc && on_grid && (s_axis_tuser == ACT_LOAD);
      mem_wdata = {in_v_prior, in_u_prior, in_v_prior, in_u_prior, in_rho_diff, in_rho_mean};
    end else if (state_q == ST_DEC) begin
      mem_we = accept_w;
    end
  end

  ffmu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GRID_SIZE * GRID_SIZE)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // -------------------------------------------------------- operand select
  logic [3:0]         site;
  logic [3:0]         up_i, dn_i, rt_i, lf_i;
  logic signed [31:0] fu_s, fv_s, fu_up, fu_dn, fu_rt, fu_lf;
  logic signed [31:0] fv_up, fv_dn, fv_rt, fv_lf;
  logic signed [31:0] mul_a, mul_b, prod;
  logic signed [31:0] sub_x, sub_y, diff;
  logic signed [31:0] add_x, add_y, sum;

  // Residual order N,S,E,W,C; gradient order N,S,E,W.
  always_comb begin
    if (state_q == ST_RES && j_q == 3'd4) begin
      site = WIN_C;
    end else begin
      site = 4'(j_q) + 4'd1;
    end
  end

  assign up_i = nbr(site, DIR_UP);
  assign dn_i = nbr(site, DIR_DOWN);
  assign rt_i = nbr(site, DIR_RIGHT);
  assign lf_i = nbr(site, DIR_LEFT);

  // The centre slot carries the flow under evaluation.
  assign fu_s  = (site == WIN_C) ? ucen_q : win_u_q[site];
  assign fv_s  = (site == WIN_C) ? vcen_q : win_v_q[site];
  assign fu_up = (up_i == WIN_C) ? ucen_q : win_u_q[up_i];
  assign fu_dn = (dn_i == WIN_C) ? ucen_q : win_u_q[dn_i];
  assign fu_rt = (rt_i == WIN_C) ? ucen_q : win_u_q[rt_i];
  assign fu_lf = (lf_i == WIN_C) ? ucen_q : win_u_q[lf_i];
  assign fv_up = (up_i == WIN_C) ? vcen_q : win_v_q[up_i];
  assign fv_dn = (dn_i == WIN_C) ? vcen_q : win_v_q[dn_i];
  assign fv_rt = (rt_i == WIN_C) ? vcen_q : win_v_q[rt_i];
  assign fv_lf = (lf_i == WIN_C) ? vcen_q : win_v_q[lf_i];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_x = '0;
    sub_y = '0;
    add_x = acc_q;
    add_y = m_q;
    unique case (state_q)
      ST_RES: begin
        unique case (k_q)
          4'd0: begin
            mul_a = phi1_q; mul_b = win_m_q[site];
            sub_x = fu_dn;  sub_y = fu_up;
          end
          4'd1: begin
            mul_a = p_q;   mul_b = d_q;
            sub_x = fv_rt; sub_y = fv_lf;
          end
          4'd2: begin
            mul_a = p_q; mul_b = d_q;
            sub_x = win_m_q[dn_i]; sub_y = win_m_q[up_i];
          end
          4'd3: begin
            mul_a = phi2_q; mul_b = d_q;
            sub_x = win_m_q[rt_i]; sub_y = win_m_q[lf_i];
          end
          4'd4: begin
            mul_a = p_q; mul_b = fu_s;
          end
          4'd5: begin
            mul_a = phi2_q; mul_b = d_q;
          end
          4'd6: begin
            mul_a = p_q; mul_b = fv_s;
          end
          4'd9: begin
            add_x = jd_q; add_y = acc_q;
          end
          default: ;
        endcase
      end
      ST_GRAD: begin
        mul_a = d_q;
        mul_b = d_q;
        unique case (k_q)
          4'd0: begin sub_x = fu_dn; sub_y = fu_up; end
          4'd1: begin sub_x = fu_rt; sub_y = fu_lf; end
          4'd2: begin sub_x = fv_dn; sub_y = fv_up; end
          4'd3: begin sub_x = fv_rt; sub_y = fv_lf; end
          4'd6: begin add_x = jr_q;  add_y = acc_q; end
          default: ;
        endcase
      end
      ST_FIN: begin
        unique case (k_q)
          4'd0: begin
            mul_a = alpha_q; mul_b = jr_q;
            sub_x = ucen_q;  sub_y = cpx_q;
          end
          4'd1: begin
            mul_a = d_q;    mul_b = d_q;
            sub_x = vcen_q; sub_y = cpy_q;
            add_x = jd_q;
          end
          4'd2, 4'd4: begin
            mul_a = gamma_q; mul_b = m_q;
          end
          4'd3: begin
            mul_a = d_q; mul_b = d_q;
          end
          default: ;
        endcase
      end
      ST_DIFF: begin
        sub_x = acc_q;  sub_y = before_q;
        mul_a = temp_q; mul_b = d_q;
      end
      default: ;
    endcase
  end

  assign prod     = qmul(mul_a, mul_b);
  assign diff     = qsub(sub_x, sub_y);
  assign sum      = qadd(add_x, add_y);
  assign accept_w = (state_q == ST_DEC) && ($signed(m_q) < $signed({1'b0, thr_q}));

  // ----------------------------------------------------------- sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (on_grid && s_axis_tuser == ACT_STEP && interior) begin
            state_d = ST_FETCH;
          end else if (on_grid && (s_axis_tuser == ACT_READ || s_axis_tuser == ACT_STEP)) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_RD:    state_d = ST_OUT;
      ST_FETCH: if (k_q == 4'(WIN_N)) state_d = ST_RES;
      ST_RES:   if (k_q == 4'd9 && j_q == 3'd4) state_d = ST_GRAD;
      ST_GRAD:  if (k_q == 4'd6 && j_q == 3'd3) state_d = ST_FIN;
      ST_FIN:   if (k_q == 4'd5) state_d = pass_q ? ST_DIFF : ST_RES;
      ST_DIFF:  if (k_q == 4'd1) state_d = ST_DEC;
      ST_DEC:   state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      alpha_q     <= '0;
      temp_q      <= 32'sd1 <<< FRAC_BITS;
      phi1_q      <= '0;
      phi2_q      <= '0;
      gamma_q     <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ALPHA: alpha_q <= cfg_wdata_i;
          CFG_TEMP:  temp_q  <= cfg_wdata_i;
          CFG_PHI1:  phi1_q  <= cfg_wdata_i;
          CFG_PHI2:  phi2_q  <= cfg_wdata_i;
          CFG_GAMMA: gamma_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // step and site counters
      unique case (state_q)
        ST_IDLE: begin
          k_q    <= '0;
          j_q    <= '0;
          pass_q <= 1'b0;
        end
        ST_FETCH: k_q <= (k_q == 4'(WIN_N)) ? 4'd0 : k_q + 4'd1;
        ST_RES: begin
          if (k_q == 4'd9) begin
            k_q <= '0;
            j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        ST_GRAD: begin
          if (k_q == 4'd6) begin
            k_q <= '0;
            j_q <= (j_q == 3'd3) ? 3'd0 : j_q + 3'd1;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        ST_FIN: begin
          if (k_q == 4'd5) begin
            k_q    <= '0;
            pass_q <= 1'b1;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        ST_DIFF: k_q <= (k_q == 4'd1) ? 4'd0 : k_q + 4'd1;
        default: ;
      endcase

      if (accept_w) begin
        cnt_q <= cnt_q + 32'd1;
      end

      // output register: drop on take, load the pending result when free
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {7'd0, cnt_q, res_chg_q, res_v_q, res_u_q, res_acc_q};
    end

    unique case (state_q)
      ST_IDLE: begin
        row_q     <= in_row;
        col_q     <= in_col;
        inc_u_q   <= in_u_step;
        inc_v_q   <= in_v_step;
        thr_q     <= in_thr;
        res_acc_q <= 1'b0;
        res_chg_q <= '0;
        // load echoes the new flow; anything else not reaching memory is zero
        if (on_grid && s_axis_tuser == ACT_LOAD) begin
          res_u_q <= in_u_prior;
          res_v_q <= in_v_prior;
        end else begin
          res_u_q <= '0;
          res_v_q <= '0;
        end
      end
      ST_RD: begin
        res_u_q <= mem_rdata[95:64];
        res_v_q <= mem_rdata[127:96];
      end
      ST_FETCH: begin
        if (k_q != 4'd0) begin
          win_m_q[k_q - 4'd1] <= mem_rdata[31:0];
          win_d_q[k_q - 4'd1] <= mem_rdata[63:32];
          win_u_q[k_q - 4'd1] <= mem_rdata[95:64];
          win_v_q[k_q - 4'd1] <= mem_rdata[127:96];
        end
        if (k_q == 4'd1) begin
          cpx_q <= mem_rdata[159:128];
          cpy_q <= mem_rdata[191:160];
        end
        if (k_q == 4'(WIN_N)) begin
          ucen_q <= win_u_q[WIN_C];
          vcen_q <= win_v_q[WIN_C];
          jd_q   <= '0;
          jr_q   <= '0;
        end
      end
      ST_RES: begin
        unique case (k_q)
          4'd0: begin p_q <= prod; d_q <= diff; acc_q <= win_d_q[site]; end
          4'd1: begin m_q <= prod; d_q <= diff; end
          4'd2: begin acc_q <= sum; m_q <= prod; d_q <= diff; end
          4'd3: begin acc_q <= sum; p_q <= prod; d_q <= diff; end
          4'd4: m_q <= prod;
          4'd5: begin acc_q <= sum; p_q <= prod; end
          4'd6: m_q <= prod;
          4'd7: acc_q <= sum;
          4'd8: acc_q <= qabs(acc_q);
          4'd9: jd_q <= sum;
          default: ;
        endcase
      end
      ST_GRAD: begin
        unique case (k_q)
          4'd0: d_q <= diff;
          4'd1: begin m_q <= prod; d_q <= diff; end
          4'd2: begin acc_q <= m_q; m_q <= prod; d_q <= diff; end
          4'd3: begin acc_q <= sum; m_q <= prod; d_q <= diff; end
          4'd4: begin acc_q <= sum; m_q <= prod; end
          4'd5: acc_q <= sum;
          4'd6: jr_q <= sum;
          default: ;
        endcase
      end
      ST_FIN: begin
        unique case (k_q)
          4'd0: begin d_q <= diff; m_q <= prod; end
          4'd1: begin acc_q <= sum; m_q <= prod; d_q <= diff; end
          4'd2: m_q <= prod;
          4'd3: begin acc_q <= sum; m_q <= prod; end
          4'd4: m_q <= prod;
          4'd5: begin
            acc_q <= sum;
            // end of the first pass: hold the energy, move to proposed flow
            if (!pass_q) begin
              before_q <= sum;
              ucen_q   <= qadd(win_u_q[WIN_C], inc_u_q);
              vcen_q   <= qadd(win_v_q[WIN_C], inc_v_q);
              jd_q     <= '0;
              jr_q     <= '0;
            end
          end
          default: ;
        endcase
      end
      ST_DIFF: begin
        if (k_q == 4'd0) begin
          d_q <= diff;
        end else begin
          m_q <= prod;
        end
      end
      ST_DEC: begin
        res_acc_q <= accept_w;
        res_chg_q <= m_q;
        res_u_q   <= accept_w ? ucen_q : win_u_q[WIN_C];
        res_v_q   <= accept_w ? vcen_q : win_v_q[WIN_C];
      end
      default: ;
    endcase
  end

endmodule
